>>> src/ffr_pkg.sv
// Shared types and codes for the firmware frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package ffr_pkg;

	// Input opcodes
	localparam logic [1:0] OP_ARM  = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Result kinds
	localparam logic KIND_PROGRAM = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_FRAME   = 2'd2;
	localparam logic [1:0] ST_LENGTH  = 2'd3;

	// Frame header bytes
	localparam logic [7:0] HEAD_FIRST  = 8'h5A;
	localparam logic [7:0] HEAD_SECOND = 8'hA5;

	// Configuration register indexes and reset values
	localparam logic [1:0]  CFG_APP_BASE = 2'd0;
	localparam logic [1:0]  CFG_TIMEOUT  = 2'd1;
	localparam logic [1:0]  CFG_MAX_LEN  = 2'd2;
	localparam logic [31:0] APP_BASE_RST = 32'h0801_0000;
	localparam logic [15:0] TIMEOUT_RST  = 16'd5000;
	localparam logic [15:0] MAX_LEN_RST  = 16'hFFFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} ffr_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] program_address;
		logic [15:0] program_data;
		logic [1:0]  status_code;
	} ffr_out_t;

endpackage
`default_nettype wire

>>> src/ffr_parser.sv
// Frame parser: configuration registers, frame state and per-item result logic.
`timescale 1ns / 1ps
`default_nettype none
module ffr_parser import ffr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        step,
	input  wire ffr_in_t     item,
	output logic             emit,
	output ffr_out_t         result
);

	// Phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_HEAD0   = 3'd1;
	localparam logic [2:0] PH_HEAD1   = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_LEN_HI  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_CHECK   = 3'd6;

	logic [31:0] app_base_q;
	logic [15:0] timeout_q;
	logic [15:0] max_len_q;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] frame_len_q, frame_len_d;
	logic [15:0] offset_q, offset_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  held_q, held_d;
	logic [15:0] idle_q, idle_d;

	// Configuration writes; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_base_q <= APP_BASE_RST;
			timeout_q  <= TIMEOUT_RST;
			max_len_q  <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_APP_BASE: app_base_q <= cfg_data;
				CFG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
				CFG_MAX_LEN:  max_len_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Next state and result for the item in the input register
	always_comb begin
		logic [16:0] tick_next;
		logic [15:0] len_new;
		logic        last;
		logic [31:0] half_addr;

		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		offset_d    = offset_q;
		sum_d       = sum_q;
		held_d      = held_q;
		idle_d      = idle_q;
		emit        = 1'b0;
		result      = '0;

		tick_next = {1'b0, idle_q} + 17'd1;
		len_new   = {item.data_byte, frame_len_q[7:0]};
		last      = ({1'b0, offset_q} + 17'd1) >= {1'b0, frame_len_q};
		// the low byte of a halfword always sits at an even offset
		half_addr = app_base_q + {16'd0, offset_q[15:1], 1'b0};

		if (step) begin
			unique case (item.opcode)
				OP_ARM: begin
					phase_d     = PH_HEAD0;
					frame_len_d = '0;
					offset_d    = '0;
					sum_d       = '0;
					held_d      = '0;
					idle_d      = '0;
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (tick_next > {1'b0, timeout_q}) begin
							emit               = 1'b1;
							result.result_kind = KIND_STATUS;
							result.status_code = ST_TIMEOUT;
							phase_d            = PH_IDLE;
							idle_d             = '0;
						end else begin
							idle_d = tick_next[15:0];
						end
					end
				end
				OP_BYTE: begin
					if (phase_q != PH_IDLE) begin
						idle_d = '0;
						unique case (phase_q)
							PH_HEAD0: begin
								if (item.data_byte != HEAD_FIRST) begin
									emit               = 1'b1;
									result.result_kind = KIND_STATUS;
									result.status_code = ST_FRAME;
									phase_d            = PH_IDLE;
								end else begin
									phase_d = PH_HEAD1;
								end
							end
							PH_HEAD1: begin
								if (item.data_byte != HEAD_SECOND) begin
									emit               = 1'b1;
									result.result_kind = KIND_STATUS;
									result.status_code = ST_FRAME;
									phase_d            = PH_IDLE;
								end else begin
									phase_d = PH_LEN_LO;
								end
							end
							PH_LEN_LO: begin
								frame_len_d = {8'd0, item.data_byte};
								phase_d     = PH_LEN_HI;
							end
							PH_LEN_HI: begin
								frame_len_d = len_new;
								if (len_new == '0 || len_new > max_len_q) begin
									emit               = 1'b1;
									result.result_kind = KIND_STATUS;
									result.status_code = ST_LENGTH;
									phase_d            = PH_IDLE;
								end else begin
									offset_d = '0;
									sum_d    = '0;
									phase_d  = PH_PAYLOAD;
								end
							end
							PH_PAYLOAD: begin
								sum_d    = sum_q + item.data_byte;
								offset_d = offset_q + 16'd1;
								if (!offset_q[0]) begin
									held_d = item.data_byte;
									// odd length: pad the final byte
									if (last) begin
										emit                   = 1'b1;
										result.result_kind     = KIND_PROGRAM;
										result.program_address = half_addr;
										result.program_data    = {8'd0, item.data_byte};
									end
								end else begin
									emit                   = 1'b1;
									result.result_kind     = KIND_PROGRAM;
									result.program_address = half_addr;
									result.program_data    = {item.data_byte, held_q};
								end
								if (last) begin
									phase_d = PH_CHECK;
								end
							end
							PH_CHECK: begin
								emit               = 1'b1;
								result.result_kind = KIND_STATUS;
								result.status_code = (item.data_byte == sum_q) ? ST_OK
								                                               : ST_FRAME;
								phase_d            = PH_IDLE;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			frame_len_q <= '0;
			offset_q    <= '0;
			sum_q       <= '0;
			held_q      <= '0;
			idle_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			offset_q    <= offset_d;
			sum_q       <= sum_d;
			held_q      <= held_d;
			idle_q      <= idle_d;
		end
	end

endmodule
`default_nettype wire

>>> src/firmware_frame_receiver.sv
// Top level of the firmware frame receiver: input register, parser and result register.
// Each item passes the input register, the parser and then the result register.
// One item per cycle unless a stalled result blocks; both registers advance together.
// An item that causes no result still takes one pass through the input register.
// Reset (arst_n low) clears control state, restores register defaults and leaves the block idle.
`timescale 1ns / 1ps
`default_nettype none
module firmware_frame_receiver import ffr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire ffr_in_t     item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output ffr_out_t         result
);

	logic     valid_s1;
	ffr_in_t  item_s1;
	logic     advance;
	logic     emit;
	ffr_out_t res_d;
	logic     res_valid_q;
	ffr_out_t res_q;

	// The input register moves on when the result register is free or being taken
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	ffr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.step     (advance),
		.item     (item_s1),
		.emit     (emit),
		.result   (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Checks
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> result_valid)
		else $error("result lost after emit");

	a_no_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !emit |=> !result_valid)
		else $error("result repeated or invented");

	a_in_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> valid_s1)
		else $error("accepted item not in input register");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_STATUS |->
			result.program_address == '0 && result.program_data == '0)
		else $error("status result carries program fields");

endmodule
`default_nettype wire
